[sv/svo_pkg.sv]
// Shared types, register codes and the sine table for the sine oscillator with vibrato.
package svo_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AMPLITUDE = 2'd0,
    CFG_BASE_INC  = 2'd1,
    CFG_LFO_INC   = 2'd2,
    CFG_VIB_DEPTH = 2'd3
  } svo_cfg_idx_t;

  // Operand pair fed to the shared multiplier
  typedef enum logic [1:0] {
    MUL_FRAC  = 2'd0,
    MUL_DEPTH = 2'd1,
    MUL_AMP   = 2'd2
  } svo_mul_sel_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE      = 4'd0,
    ST_LFO_FETCH = 4'd1,
    ST_LFO_MUL   = 4'd2,
    ST_LFO_SUM   = 4'd3,
    ST_DEPTH_MUL = 4'd4,
    ST_STEP      = 4'd5,
    ST_MAIN_MUL  = 4'd6,
    ST_MAIN_SUM  = 4'd7,
    ST_AMP_MUL   = 4'd8,
    ST_OUT       = 4'd9
  } svo_state_t;

  // Controller to datapath strobes
  typedef struct packed {
    logic         fetch_lfo;
    logic         fetch_main;
    logic         mul_en;
    svo_mul_sel_t mul_sel;
    logic         sum_en;
    logic         step_en;
    logic         finish;
  } svo_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic amp_zero;
    logic out_free;
  } svo_status_t;

  // First quarter of a full-scale sine, 65 points
  localparam logic signed [15:0] QUARTER_WAVE [65] = '{
    16'sd0,     16'sd804,   16'sd1608,  16'sd2410,  16'sd3212,  16'sd4011,  16'sd4808,
    16'sd5602,  16'sd6393,  16'sd7179,  16'sd7962,  16'sd8739,  16'sd9512,  16'sd10278,
    16'sd11039, 16'sd11793, 16'sd12539, 16'sd13279, 16'sd14010, 16'sd14732, 16'sd15446,
    16'sd16151, 16'sd16846, 16'sd17530, 16'sd18204, 16'sd18868, 16'sd19519, 16'sd20159,
    16'sd20787, 16'sd21403, 16'sd22005, 16'sd22594, 16'sd23170, 16'sd23731, 16'sd24279,
    16'sd24811, 16'sd25329, 16'sd25832, 16'sd26319, 16'sd26790, 16'sd27245, 16'sd27683,
    16'sd28105, 16'sd28510, 16'sd28898, 16'sd29268, 16'sd29621, 16'sd29956, 16'sd30273,
    16'sd30571, 16'sd30852, 16'sd31113, 16'sd31356, 16'sd31580, 16'sd31785, 16'sd31971,
    16'sd32137, 16'sd32285, 16'sd32412, 16'sd32521, 16'sd32609, 16'sd32678, 16'sd32728,
    16'sd32757, 16'sd32767
  };

  // Full-cycle sine point 0..256, folded out of the quarter wave
  function automatic logic signed [15:0] sine_rom_at(input logic [8:0] i);
    logic [6:0]        k;
    logic [7:0]        mirror;
    logic [6:0]        j;
    logic signed [15:0] mag;
    k      = i[6:0];
    mirror = 8'd128 - {1'b0, k};
    j      = (k > 7'd64) ? mirror[6:0] : k;
    mag    = QUARTER_WAVE[j];
    return i[7] ? -mag : mag;
  endfunction

endpackage

[sv/svo_in_if.sv]
// Input channel: one sample tick per transfer.
interface svo_in_if;
  logic valid;
  logic ready;
  logic sample_tick;

  modport source (output valid, output sample_tick, input ready);
  modport sink   (input valid, input sample_tick, output ready);
endinterface

[sv/svo_out_if.sv]
// Result channel: one signed audio sample per transfer.
interface svo_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

[sv/svo_ctrl.sv]
// Sequencer that steps the datapath through the vibrato and main sine evaluation.
module svo_ctrl import svo_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_tick,
  output logic        in_ready,
  input  svo_status_t status,
  output svo_cmd_t    cmd
);

  svo_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and strobes
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_sel = MUL_FRAC;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        // a zero tick is dropped; a muted tick skips straight to the result
        if (in_valid && in_tick) begin
          state_nxt = status.amp_zero ? ST_OUT : ST_LFO_FETCH;
        end
      end
      ST_LFO_FETCH: begin
        cmd.fetch_lfo = 1'b1;
        state_nxt     = ST_LFO_MUL;
      end
      ST_LFO_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_FRAC;
        state_nxt   = ST_LFO_SUM;
      end
      ST_LFO_SUM: begin
        cmd.sum_en = 1'b1;
        state_nxt  = ST_DEPTH_MUL;
      end
      ST_DEPTH_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DEPTH;
        state_nxt   = ST_STEP;
      end
      ST_STEP: begin
        cmd.step_en    = 1'b1;
        cmd.fetch_main = 1'b1;
        state_nxt      = ST_MAIN_MUL;
      end
      ST_MAIN_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_FRAC;
        state_nxt   = ST_MAIN_SUM;
      end
      ST_MAIN_SUM: begin
        cmd.sum_en = 1'b1;
        state_nxt  = ST_AMP_MUL;
      end
      ST_AMP_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_AMP;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[sv/svo_dp.sv]
// Datapath: configuration, phase accumulators, table interpolation and shared multiplier.
module svo_dp import svo_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  svo_cmd_t              cmd,
  output svo_status_t           status,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic signed [15:0]    out_sample
);

  // Configuration registers
  logic [16:0] amplitude_r;
  logic [30:0] base_inc_r;
  logic [31:0] lfo_inc_r;
  logic [30:0] vib_depth_r;

  // Phases and working registers
  logic [31:0]        main_phase_r, main_phase_nxt;
  logic [31:0]        lfo_phase_r, lfo_phase_nxt;
  logic signed [15:0] base_r;
  logic signed [16:0] diff_r;
  logic [15:0]        frac_r;
  logic signed [63:0] prod_r, prod_nxt;
  logic signed [31:0] raw_r, raw_nxt;
  logic [31:0]        step_r, step_nxt;
  logic               out_valid_r;
  logic signed [15:0] out_sample_r, out_sample_nxt;

  // Table fetch
  logic [31:0]        fetch_phase;
  logic [8:0]         idx_lo;
  logic [8:0]         idx_hi;
  logic signed [15:0] pt_lo;
  logic signed [15:0] pt_hi;
  logic signed [16:0] diff_nxt;

  // Multiplier operands
  logic signed [31:0] op_a;
  logic signed [31:0] op_b;

  // Step and sample shaping
  logic signed [32:0] offset;
  logic signed [33:0] step_sum;
  logic signed [31:0] prod_hi;

  // Write configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amplitude_r <= '0;
      base_inc_r  <= '0;
      lfo_inc_r   <= '0;
      vib_depth_r <= '0;
    end else if (cfg_we) begin
      case (svo_cfg_idx_t'(cfg_index))
        CFG_AMPLITUDE: amplitude_r <= cfg_data[16:0];
        CFG_BASE_INC:  base_inc_r  <= cfg_data[30:0];
        CFG_LFO_INC:   lfo_inc_r   <= cfg_data;
        CFG_VIB_DEPTH: vib_depth_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Look up the two neighbouring table points of the selected phase
  assign fetch_phase = cmd.fetch_main ? main_phase_r : lfo_phase_r;
  assign idx_lo      = {1'b0, fetch_phase[31:24]};
  assign idx_hi      = idx_lo + 9'd1;
  assign pt_lo       = sine_rom_at(idx_lo);
  assign pt_hi       = sine_rom_at(idx_hi);
  assign diff_nxt    = {pt_hi[15], pt_hi} - {pt_lo[15], pt_lo};

  always_ff @(posedge clk) begin
    if (cmd.fetch_lfo || cmd.fetch_main) begin
      base_r <= pt_lo;
      diff_r <= diff_nxt;
      frac_r <= fetch_phase[23:8];
    end
  end

  // Shared multiplier
  always_comb begin
    case (cmd.mul_sel)
      MUL_FRAC: begin
        op_a = 32'(diff_r);
        op_b = $signed({16'h0000, frac_r});
      end
      MUL_DEPTH: begin
        op_a = raw_r;
        op_b = $signed({1'b0, vib_depth_r});
      end
      MUL_AMP: begin
        op_a = raw_r;
        op_b = $signed({15'h0000, amplitude_r});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod_nxt = op_a * op_b;

  // Interpolated value: point times full weight plus slope times fraction
  assign raw_nxt = $signed({base_r, 16'h0000}) + prod_r[31:0];

  // Modulated step, floored by the shift, clamped at zero
  assign offset   = prod_r[63:31];
  assign step_sum = {offset[32], offset} + $signed({3'b000, base_inc_r});
  assign step_nxt = step_sum[33] ? 32'h0 : step_sum[31:0];

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (cmd.sum_en) begin
      raw_r <= raw_nxt;
    end
    if (cmd.step_en) begin
      step_r <= step_nxt;
    end
  end

  // Saturate the scaled sample to 16 bits; zero while muted
  assign prod_hi = prod_r[63:32];

  always_comb begin
    if (amplitude_r == 17'd0) begin
      out_sample_nxt = '0;
    end else if ((&prod_hi[31:15]) || !(|prod_hi[31:15])) begin
      out_sample_nxt = prod_hi[15:0];
    end else if (prod_hi[31]) begin
      out_sample_nxt = 16'sh8000;
    end else begin
      out_sample_nxt = 16'sh7FFF;
    end
  end

  // Advance phases; muted ticks use the plain step and leave the vibrato still
  always_comb begin
    if (amplitude_r == 17'd0) begin
      main_phase_nxt = main_phase_r + {1'b0, base_inc_r};
      lfo_phase_nxt  = lfo_phase_r;
    end else begin
      main_phase_nxt = main_phase_r + step_r;
      lfo_phase_nxt  = lfo_phase_r + lfo_inc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_phase_r <= '0;
      lfo_phase_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.finish) begin
        main_phase_r <= main_phase_nxt;
        lfo_phase_r  <= lfo_phase_nxt;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_sample_r <= out_sample_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sample      = out_sample_r;
  assign status.amp_zero = (amplitude_r == 17'd0);
  assign status.out_free = !out_valid_r || out_ready;

endmodule

[sv/sine_oscillator_with_vibrato_unit.sv]
// Sine oscillator with vibrato: a DDS sine whose phase step follows a low-frequency sine.
// The sequencer walks nine datapath steps through one shared 32x32 multiplier and takes
//   no new tick until it is back in idle; its last step holds while the output register
//   is full. A muted tick skips straight to that last step; a zero tick is dropped.
// The output register lets a new tick be taken while the last sample still waits.
// Reset (synchronous, rst_n low) clears both phases, the config, the state and the output valid.
module sine_oscillator_with_vibrato_unit import svo_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  svo_in_if.sink                in_chan,
  svo_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  svo_cmd_t    cmd;
  svo_status_t status;

  // Sequencer
  svo_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_tick  (in_chan.sample_tick),
    .in_ready (in_chan.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath
  svo_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .status     (status),
    .out_ready  (out_chan.ready),
    .out_valid  (out_chan.valid),
    .out_sample (out_chan.sample_out)
  );

endmodule

[sv/svo_checker.sv]
// Port-level checks for the sine oscillator with vibrato, bound to the top level.
module svo_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_tick,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_sample
);

  // A waiting sample holds until transferred
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample))
    else $error("sample changed or dropped while stalled");

  // A real tick starts work, so no further tick is taken next cycle
  a_busy_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_tick |=> !in_ready)
    else $error("tick taken while the previous one is in progress");

  // A zero tick leaves the block ready
  a_zero_tick_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_tick |=> in_ready)
    else $error("zero tick started work");

  // A new sample only ever appears at the end of work on a tick
  a_sample_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("sample appeared without a tick in progress");

endmodule

bind sine_oscillator_with_vibrato_unit svo_checker u_svo_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .in_tick    (in_chan.sample_tick),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_sample (out_chan.sample_out)
);
